>>> rtl/sst_pkg.sv
// ----------------------------------------------------------------------------
// sst_pkg
// Shared types and constants for the scoped symbol table.
// ----------------------------------------------------------------------------
`default_nettype none

package sst_pkg;

  localparam int MAX_FRAMES_DEF   = 32;
  localparam int MAX_BINDINGS_DEF = 256;
  localparam int KEY_BITS_DEF     = 32;
  localparam int VALUE_BITS_DEF   = 32;

  typedef enum logic [2:0] {
    CMD_PUSH       = 3'd0,
    CMD_POP        = 3'd1,
    CMD_DEFINE     = 3'd2,
    CMD_LOOKUP_ALL = 3'd3,
    CMD_LOOKUP_TOP = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_FRAMES_FULL = 3'd1,
    ST_POP_GLOBAL  = 3'd2,
    ST_BAD_ARG     = 3'd3,
    ST_DUPLICATE   = 3'd4,
    ST_BINDS_FULL  = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_POP_WAIT,
    S_SCAN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [2:0]  command;
    logic        function_flag;
    logic [31:0] name_key;
    logic [31:0] symbol_value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        found;
    logic [31:0] found_value;
    logic [4:0]  scope_depth;
    logic        at_function_boundary;
  } out_item_t;

  // handshake between the sequencer and the scan unit
  typedef struct packed {
    logic done;
    logic found;
  } scan_stat_t;

endpackage

`default_nettype wire

>>> rtl/sst_ram.sv
// ----------------------------------------------------------------------------
// sst_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module sst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/sst_scan.sv
// ----------------------------------------------------------------------------
// sst_scan
// Newest-first walk over the binding memory, one entry per cycle, with a
// single key comparator against the registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sst_scan #(
  parameter int MAX_BINDINGS = 256,
  parameter int KEY_BITS     = 32,
  parameter int VALUE_BITS   = 32,
  localparam int CNT_W = $clog2(MAX_BINDINGS + 1),
  localparam int IDX_W = (MAX_BINDINGS > 1) ? $clog2(MAX_BINDINGS) : 1
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [CNT_W-1:0]               hi,
  input  logic [CNT_W-1:0]               lo,
  input  logic [KEY_BITS-1:0]            key,
  output logic                           rd_en,
  output logic [IDX_W-1:0]               rd_addr,
  input  logic [KEY_BITS+VALUE_BITS-1:0] rd_data,
  output sst_pkg::scan_stat_t            stat,
  output logic [VALUE_BITS-1:0]          value
);

  import sst_pkg::*;

  logic [CNT_W-1:0]      ptr_r, ptr_nxt, ptr_dec;
  logic                  pend_r, pend_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic                  found_r, found_nxt;
  logic [VALUE_BITS-1:0] value_r, value_nxt;
  logic [KEY_BITS-1:0]   rd_key;
  logic [VALUE_BITS-1:0] rd_val;
  logic                  hit;

  assign rd_key  = rd_data[KEY_BITS+VALUE_BITS-1:VALUE_BITS];
  assign rd_val  = rd_data[VALUE_BITS-1:0];
  assign ptr_dec = ptr_r - 1'b1;
  assign hit     = pend_r && (rd_key == key);

  always_comb begin
    ptr_nxt   = ptr_r;
    pend_nxt  = 1'b0;
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    found_nxt = found_r;
    value_nxt = value_r;
    rd_en     = 1'b0;
    rd_addr   = ptr_dec[IDX_W-1:0];
    if (start) begin
      ptr_nxt   = hi;
      busy_nxt  = 1'b1;
      found_nxt = 1'b0;
    end else if (busy_r) begin
      if (hit) begin
        busy_nxt  = 1'b0;
        done_nxt  = 1'b1;
        found_nxt = 1'b1;
        value_nxt = rd_val;
      end else if (ptr_r > lo) begin
        // read lands next cycle, compare happens then
        rd_en    = 1'b1;
        ptr_nxt  = ptr_dec;
        pend_nxt = 1'b1;
      end else begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      pend_r  <= 1'b0;
      done_r  <= 1'b0;
      found_r <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      pend_r  <= pend_nxt;
      done_r  <= done_nxt;
      found_r <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r   <= ptr_nxt;
    value_r <= value_nxt;
  end

  assign stat.done  = done_r;
  assign stat.found = found_r;
  assign value      = value_r;

endmodule

`default_nettype wire

>>> rtl/scoped_symbol_table_top.sv
// ----------------------------------------------------------------------------
// scoped_symbol_table_top
// Nested scope table: frame stack over one shared binding memory.
// ----------------------------------------------------------------------------
// usage:
//   in_valid/in_ready/in_data carry one command beat (push, pop, define,
//   lookup over all frames, lookup in the top frame). out_valid/out_ready/
//   out_data return exactly one result beat per command.
//   one command at a time: in_ready is high only while the sequencer idles.
//   push, pop, unknown commands and commands rejected on their arguments go
//   from the execute state straight to the finish state; a pop that leaves a
//   nested frame on top first waits in S_POP_WAIT for the frame memory read.
//   define and lookups walk the bindings newest first, one entry per cycle
//   through the single key comparator, visiting at most MAX_BINDINGS entries.
//   in_ready rises with out_valid.
//   the result sits in an output register: a new command is accepted while
//   it waits, and the sequencer holds the next result until out_ready.
//   reset leaves only the global frame and an empty binding table; no
//   clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module scoped_symbol_table_top #(
  parameter int MAX_FRAMES   = sst_pkg::MAX_FRAMES_DEF,
  parameter int MAX_BINDINGS = sst_pkg::MAX_BINDINGS_DEF,
  parameter int KEY_BITS     = sst_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS   = sst_pkg::VALUE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sst_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output sst_pkg::out_item_t out_data
);

  import sst_pkg::*;

  localparam int FRAME_CNT_W = $clog2(MAX_FRAMES + 1);
  localparam int FRAME_IDX_W = $clog2(MAX_FRAMES);
  localparam int BIND_CNT_W  = $clog2(MAX_BINDINGS + 1);
  localparam int BIND_IDX_W  = (MAX_BINDINGS > 1) ? $clog2(MAX_BINDINGS) : 1;
  localparam int BIND_W      = KEY_BITS + VALUE_BITS;
  localparam int FRAME_W     = BIND_CNT_W + 1;

  state_t                state_r, state_nxt;
  logic [2:0]            cmd_r, cmd_nxt;
  logic                  flag_r, flag_nxt;
  logic [KEY_BITS-1:0]   key_r, key_nxt;
  logic [VALUE_BITS-1:0] val_r, val_nxt;
  logic [FRAME_CNT_W-1:0] frame_total_r, frame_total_nxt;
  logic [BIND_CNT_W-1:0]  bind_total_r, bind_total_nxt;
  logic [BIND_CNT_W-1:0]  top_first_r, top_first_nxt;
  logic                  top_func_r, top_func_nxt;
  status_t               status_r, status_nxt;
  logic                  found_r, found_nxt;
  logic [VALUE_BITS-1:0] fval_r, fval_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_data_r, out_data_nxt;

  logic [KEY_BITS+31:0]   key_ext;
  logic [VALUE_BITS+31:0] val_ext;
  logic [VALUE_BITS-1:0]  fval_sel;
  logic [VALUE_BITS+31:0] fval_ext;
  logic [FRAME_CNT_W+4:0] depth_ext;

  logic                  frames_full, at_global, arg_bad, binds_full, out_slot;

  // frame memory
  logic                   frame_we, frame_re;
  logic [FRAME_IDX_W-1:0] frame_waddr, frame_raddr;
  logic [FRAME_W-1:0]     frame_wdata, frame_rdata;

  // binding memory and scan unit
  logic                   bind_we, bind_re;
  logic [BIND_IDX_W-1:0]  bind_waddr, bind_raddr;
  logic [BIND_W-1:0]      bind_wdata, bind_rdata;
  logic                   scan_start;
  logic [BIND_CNT_W-1:0]  scan_lo;
  scan_stat_t             scan_st;
  logic [VALUE_BITS-1:0]  scan_value;

  // low bits of the fixed-width port fields, zero extended when narrower
  assign key_ext = {{KEY_BITS{1'b0}}, in_data.name_key};
  assign val_ext = {{VALUE_BITS{1'b0}}, in_data.symbol_value};

  assign frames_full = (frame_total_r == FRAME_CNT_W'(MAX_FRAMES));
  assign at_global   = (frame_total_r == FRAME_CNT_W'(1));
  assign arg_bad     = (key_r == '0) || (val_r == '0);
  assign binds_full  = (bind_total_r == BIND_CNT_W'(MAX_BINDINGS));
  assign out_slot    = !out_valid_r || out_ready;

  assign in_ready = (state_r == S_IDLE);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        case (cmd_r)
          CMD_POP: begin
            if (!at_global && frame_total_r != FRAME_CNT_W'(2)) begin
              state_nxt = S_POP_WAIT;
            end else begin
              state_nxt = S_FINISH;
            end
          end
          CMD_DEFINE: begin
            state_nxt = arg_bad ? S_FINISH : S_SCAN;
          end
          CMD_LOOKUP_ALL, CMD_LOOKUP_TOP: begin
            state_nxt = (key_r == '0) ? S_FINISH : S_SCAN;
          end
          default: begin
            state_nxt = S_FINISH;
          end
        endcase
      end
      S_POP_WAIT: begin
        state_nxt = S_FINISH;
      end
      S_SCAN: begin
        if (scan_st.done) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_slot) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // outputs and datapath
  always_comb begin
    cmd_nxt         = cmd_r;
    flag_nxt        = flag_r;
    key_nxt         = key_r;
    val_nxt         = val_r;
    frame_total_nxt = frame_total_r;
    bind_total_nxt  = bind_total_r;
    top_first_nxt   = top_first_r;
    top_func_nxt    = top_func_r;
    status_nxt      = status_r;
    found_nxt       = found_r;
    fval_nxt        = fval_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_data_nxt    = out_data_r;
    frame_we        = 1'b0;
    frame_re        = 1'b0;
    frame_waddr     = frame_total_r[FRAME_IDX_W-1:0];
    frame_raddr     = FRAME_IDX_W'(frame_total_r - FRAME_CNT_W'(2));
    frame_wdata     = {bind_total_r, flag_r};
    bind_we         = 1'b0;
    bind_waddr      = bind_total_r[BIND_IDX_W-1:0];
    bind_wdata      = {key_r, val_r};
    scan_start      = 1'b0;
    scan_lo         = (cmd_r == CMD_LOOKUP_ALL) ? '0 : top_first_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt  = in_data.command;
          flag_nxt = in_data.function_flag;
          key_nxt  = key_ext[KEY_BITS-1:0];
          val_nxt  = val_ext[VALUE_BITS-1:0];
        end
      end
      S_EXEC: begin
        status_nxt = ST_OK;
        found_nxt  = 1'b0;
        case (cmd_r)
          CMD_PUSH: begin
            if (frames_full) begin
              status_nxt = ST_FRAMES_FULL;
            end else begin
              frame_we        = 1'b1;
              top_first_nxt   = bind_total_r;
              top_func_nxt    = flag_r;
              frame_total_nxt = frame_total_r + 1'b1;
            end
          end
          CMD_POP: begin
            if (at_global) begin
              status_nxt = ST_POP_GLOBAL;
            end else begin
              bind_total_nxt  = top_first_r;
              frame_total_nxt = frame_total_r - 1'b1;
              if (frame_total_r == FRAME_CNT_W'(2)) begin
                // back to the global frame, which is never stored
                top_first_nxt = '0;
                top_func_nxt  = 1'b0;
              end else begin
                frame_re = 1'b1;
              end
            end
          end
          CMD_DEFINE: begin
            if (arg_bad) begin
              status_nxt = ST_BAD_ARG;
            end else begin
              scan_start = 1'b1;
            end
          end
          CMD_LOOKUP_ALL, CMD_LOOKUP_TOP: begin
            scan_start = (key_r != '0);
          end
          default: begin
          end
        endcase
      end
      S_POP_WAIT: begin
        top_first_nxt = frame_rdata[FRAME_W-1:1];
        top_func_nxt  = frame_rdata[0];
      end
      S_SCAN: begin
        if (scan_st.done) begin
          if (cmd_r == CMD_DEFINE) begin
            if (scan_st.found) begin
              status_nxt = ST_DUPLICATE;
            end else if (binds_full) begin
              status_nxt = ST_BINDS_FULL;
            end else begin
              bind_we        = 1'b1;
              bind_total_nxt = bind_total_r + 1'b1;
            end
          end else begin
            found_nxt = scan_st.found;
            fval_nxt  = scan_value;
          end
        end
      end
      S_FINISH: begin
        if (out_slot) begin
          out_valid_nxt                     = 1'b1;
          out_data_nxt.status               = status_r;
          out_data_nxt.found                = found_r;
          out_data_nxt.found_value          = fval_ext[31:0];
          out_data_nxt.scope_depth          = depth_ext[4:0];
          out_data_nxt.at_function_boundary = top_func_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign fval_sel  = found_r ? fval_r : '0;
  assign fval_ext  = {32'd0, fval_sel};
  assign depth_ext = {5'd0, frame_total_r - FRAME_CNT_W'(1)};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      frame_total_r <= FRAME_CNT_W'(1);
      bind_total_r  <= '0;
      top_first_r   <= '0;
      top_func_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      frame_total_r <= frame_total_nxt;
      bind_total_r  <= bind_total_nxt;
      top_first_r   <= top_first_nxt;
      top_func_r    <= top_func_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    flag_r     <= flag_nxt;
    key_r      <= key_nxt;
    val_r      <= val_nxt;
    status_r   <= status_nxt;
    found_r    <= found_nxt;
    fval_r     <= fval_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  sst_ram #(
    .WIDTH (FRAME_W),
    .DEPTH (MAX_FRAMES)
  ) u_frame_ram (
    .clk   (clk),
    .we    (frame_we),
    .waddr (frame_waddr),
    .wdata (frame_wdata),
    .re    (frame_re),
    .raddr (frame_raddr),
    .rdata (frame_rdata)
  );

  sst_ram #(
    .WIDTH (BIND_W),
    .DEPTH (MAX_BINDINGS)
  ) u_bind_ram (
    .clk   (clk),
    .we    (bind_we),
    .waddr (bind_waddr),
    .wdata (bind_wdata),
    .re    (bind_re),
    .raddr (bind_raddr),
    .rdata (bind_rdata)
  );

  sst_scan #(
    .MAX_BINDINGS (MAX_BINDINGS),
    .KEY_BITS     (KEY_BITS),
    .VALUE_BITS   (VALUE_BITS)
  ) u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (scan_start),
    .hi      (bind_total_r),
    .lo      (scan_lo),
    .key     (key_r),
    .rd_en   (bind_re),
    .rd_addr (bind_raddr),
    .rd_data (bind_rdata),
    .stat    (scan_st),
    .value   (scan_value)
  );

  a_frame_range: assert property (@(posedge clk) disable iff (!rst_n)
    (frame_total_r != '0) && (frame_total_r <= FRAME_CNT_W'(MAX_FRAMES)))
    else $error("frame count out of range");

  a_top_first: assert property (@(posedge clk) disable iff (!rst_n)
    top_first_r <= bind_total_r)
    else $error("top frame starts beyond the binding count");

  a_scan_done: assert property (@(posedge clk) disable iff (!rst_n)
    scan_st.done |-> (state_r == S_SCAN))
    else $error("scan finished outside the scan state");

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second command taken while one is in flight");

endmodule

`default_nettype wire

>>> verif/scoped_symbol_table_checker.sv
// ----------------------------------------------------------------------------
// scoped_symbol_table_checker
// Watches both channels of the scope table, predicts each result beat from
// a private frame stack and binding table, and counts mismatches.
// ----------------------------------------------------------------------------
module scoped_symbol_table_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  sst_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  sst_pkg::out_item_t out_data,
  output int unsigned        mismatch_count,
  output int unsigned        pending_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import sst_pkg::*;

  localparam int FRAME_CAP = MAX_FRAMES_DEF;
  localparam int BIND_CAP  = MAX_BINDINGS_DEF;
  localparam int SHOW_MAX  = 10;

  int unsigned frame_cnt;
  int unsigned bind_cnt;
  int unsigned frame_base [FRAME_CAP];
  logic        frame_fn   [FRAME_CAP];
  logic [31:0] bind_key   [BIND_CAP];
  logic [31:0] bind_val   [BIND_CAP];

  out_item_t   expected_q [$];
  int unsigned err_cnt;
  int unsigned result_idx;

  assign mismatch_count = err_cnt;
  assign pending_count  = expected_q.size();

  // newest-first search over entries [lowest, bind_cnt)
  function automatic bit find_newest(input int unsigned lowest, input logic [31:0] key,
                                     output logic [31:0] val);
    int i;
    val = '0;
    if (key == '0) return 1'b0;
    for (i = int'(bind_cnt) - 1; i >= int'(lowest); i--) begin
      if (bind_key[i] == key) begin
        val = bind_val[i];
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic out_item_t apply_command(input in_item_t cmd);
    out_item_t   res;
    int unsigned top;
    logic [31:0] hit_val;
    bit          hit;
    res     = '0;
    top     = frame_cnt - 1;
    hit_val = '0;
    hit     = 1'b0;
    case (cmd.command)
      CMD_PUSH: begin
        if (frame_cnt >= FRAME_CAP) begin
          res.status = ST_FRAMES_FULL;
        end else begin
          frame_base[frame_cnt] = bind_cnt;
          frame_fn[frame_cnt]   = cmd.function_flag;
          frame_cnt++;
        end
      end
      CMD_POP: begin
        if (frame_cnt <= 1) begin
          res.status = ST_POP_GLOBAL;
        end else begin
          bind_cnt        = frame_base[top];
          frame_base[top] = 0;
          frame_fn[top]   = 1'b0;
          frame_cnt--;
        end
      end
      CMD_DEFINE: begin
        if (cmd.name_key == '0 || cmd.symbol_value == '0) begin
          res.status = ST_BAD_ARG;
        end else if (find_newest(frame_base[top], cmd.name_key, hit_val)) begin
          res.status = ST_DUPLICATE;
        end else if (bind_cnt >= BIND_CAP) begin
          res.status = ST_BINDS_FULL;
        end else begin
          bind_key[bind_cnt] = cmd.name_key;
          bind_val[bind_cnt] = cmd.symbol_value;
          bind_cnt++;
        end
        hit_val = '0;
      end
      CMD_LOOKUP_ALL: hit = find_newest(0, cmd.name_key, hit_val);
      CMD_LOOKUP_TOP: hit = find_newest(frame_base[top], cmd.name_key, hit_val);
      default: ;
    endcase
    res.found                = hit;
    res.found_value          = hit ? hit_val : '0;
    res.scope_depth          = 5'(frame_cnt - 1);
    res.at_function_boundary = frame_fn[frame_cnt - 1];
    return res;
  endfunction

  always @(posedge clk) begin
    out_item_t exp_res;
    bit        bad;
    int        i;
    if (!rst_n) begin
      frame_cnt  = 1;
      bind_cnt   = 0;
      for (i = 0; i < FRAME_CAP; i++) begin
        frame_base[i] = 0;
        frame_fn[i]   = 1'b0;
      end
      expected_q.delete();
      err_cnt    = 0;
      result_idx = 0;
    end else begin
      // result side first so an empty queue is judged before this edge's command
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= SHOW_MAX)
            $display("[%0t] result beat %0d arrived with nothing expected: %p",
                     $time, result_idx, out_data);
        end else begin
          exp_res = expected_q.pop_front();
          bad = (out_data.status !== exp_res.status) ||
                (out_data.found !== exp_res.found) ||
                (out_data.found_value !== exp_res.found_value) ||
                (out_data.scope_depth !== exp_res.scope_depth) ||
                (out_data.at_function_boundary !== exp_res.at_function_boundary);
          if (bad) begin
            err_cnt++;
            if (err_cnt <= SHOW_MAX)
              $display("[%0t] result beat %0d differs: exp st=%0d f=%0b v=%h d=%0d fn=%0b",
                       $time, result_idx, exp_res.status, exp_res.found,
                       exp_res.found_value, exp_res.scope_depth,
                       exp_res.at_function_boundary,
                       "  got st=%0d f=%0b v=%h d=%0d fn=%0b",
                       out_data.status, out_data.found, out_data.found_value,
                       out_data.scope_depth, out_data.at_function_boundary);
          end
        end
        result_idx++;
      end
      if (in_valid && in_ready)
        expected_q.push_back(apply_command(in_data));
    end
  end

endmodule

>>> verif/scoped_symbol_table_top_tb.sv
// ----------------------------------------------------------------------------
// scoped_symbol_table_top_tb
// Drives command beats into the scope table: a directed opening, then
// random nested scopes, deep push/pop runs, table fills and noise under
// several idle and stall mixes. The checker judges every result beat.
// ----------------------------------------------------------------------------
module scoped_symbol_table_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sst_pkg::*;

  localparam int          DEPTH_MAX    = MAX_FRAMES_DEF - 1;
  localparam int          STALL_LIMIT  = 3000;
  localparam int          DRAIN_CYCLES = 300;
  localparam int          PHASE_BEATS  = 460;
  localparam int          KEY_POOL     = 12;
  localparam logic [2:0]  CMD_SPARE_LO = 3'd5;
  localparam logic [2:0]  CMD_SPARE_HI = 3'd7;
  localparam logic [31:0] KEY_ONES     = 32'hFFFF_FFFF;
  localparam logic [31:0] KEY_ONE      = 32'h0000_0001;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  int unsigned mismatch_count;
  int unsigned pending_count;
  int unsigned beats_sent     = 0;
  int          depth_now      = 0;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          quiet_cycles   = 0;
  logic [31:0] key_pool [KEY_POOL];

  scoped_symbol_table_top u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  scoped_symbol_table_checker u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .mismatch_count(mismatch_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  function automatic logic [31:0] pick_key();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return key_pool[$urandom_range(0, KEY_POOL - 1)];
  endfunction

  // one command beat; tracks the frame depth so the stimulus can steer
  task automatic issue(input logic [2:0] op, input logic fn, input logic [31:0] key,
                       input logic [31:0] val);
    in_item_t beat;
    int       gap;
    beat.command       = op;
    beat.function_flag = fn;
    beat.name_key      = key;
    beat.symbol_value  = val;
    in_data  <= beat;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent++;
    if (op == CMD_PUSH && depth_now < DEPTH_MAX) depth_now++;
    else if (op == CMD_POP && depth_now > 0) depth_now--;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input bit with_fill);
    int unsigned phase_end;
    int          pick;
    int          n;
    int          i;
    logic [2:0]  op;
    logic [31:0] key;
    logic [31:0] val;
    logic [31:0] base;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    phase_end      = beats_sent + PHASE_BEATS;
    if (with_fill) begin
      // fill the binding table from a fresh frame, poke it while full, drop it
      if (depth_now == DEPTH_MAX) issue(CMD_POP, 1'b0, $urandom, $urandom);
      issue(CMD_PUSH, $urandom_range(0, 1), $urandom, $urandom);
      base = $urandom | 32'h1;
      for (i = 0; i < MAX_BINDINGS_DEF + 4; i++) begin
        key = base + 32'(i);
        if (key == '0) key = KEY_ONE;
        issue(CMD_DEFINE, $urandom_range(0, 1), key, $urandom | 32'h8000_0000);
      end
      issue(CMD_DEFINE, 1'b0, base, $urandom | 32'h1);
      issue(CMD_DEFINE, 1'b1, '0, $urandom);
      issue(CMD_LOOKUP_ALL, 1'b0, base + 32'd7, $urandom);
      issue(CMD_LOOKUP_ALL, 1'b1, base - 32'd1, $urandom);
      issue(CMD_LOOKUP_TOP, 1'b0, pick_key(), $urandom);
      issue(CMD_POP, 1'b0, $urandom, $urandom);
    end
    while (beats_sent < phase_end) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        // climb to a full frame stack, then unwind past the global frame
        while (depth_now < DEPTH_MAX) issue(CMD_PUSH, $urandom_range(0, 1), $urandom, $urandom);
        repeat ($urandom_range(1, 2)) issue(CMD_PUSH, $urandom_range(0, 1), $urandom, $urandom);
        repeat ($urandom_range(2, 6)) begin
          op = $urandom_range(0, 1) ? CMD_DEFINE : CMD_LOOKUP_ALL;
          issue(op, $urandom_range(0, 1), pick_key(), $urandom | 32'h1);
        end
        while (depth_now > 0) begin
          issue(CMD_POP, $urandom_range(0, 1), $urandom, $urandom);
          if ($urandom_range(0, 7) == 0) issue(CMD_LOOKUP_TOP, 1'b0, pick_key(), $urandom);
        end
        issue(CMD_POP, $urandom_range(0, 1), $urandom, $urandom);
      end else if (pick < 20) begin
        repeat ($urandom_range(1, 6)) begin
          op = 3'($urandom_range(0, 7));
          // keep stray defines out of the global frame, which never drains
          if (op == CMD_DEFINE && depth_now == 0) op = CMD_LOOKUP_ALL;
          key = $urandom_range(0, 1) ? pick_key() : $urandom;
          issue(op, $urandom_range(0, 1), key, $urandom);
        end
      end else begin
        if (depth_now < DEPTH_MAX) issue(CMD_PUSH, $urandom_range(0, 1), $urandom, $urandom);
        n = $urandom_range(1, 10);
        for (i = 0; i < n; i++) begin
          pick = $urandom_range(0, 99);
          key  = pick_key();
          if (pick < 40 && depth_now > 0) begin
            val = $urandom | 32'h1;
            if ($urandom_range(0, 19) == 0) begin
              if ($urandom_range(0, 1)) key = '0;
              else val = '0;
            end
            issue(CMD_DEFINE, $urandom_range(0, 1), key, val);
          end else if (pick < 65) begin
            issue(CMD_LOOKUP_ALL, $urandom_range(0, 1), key, $urandom);
          end else if (pick < 88) begin
            issue(CMD_LOOKUP_TOP, $urandom_range(0, 1), key, $urandom);
          end else if (pick < 94) begin
            issue(CMD_PUSH, $urandom_range(0, 1), $urandom, $urandom);
          end else if (depth_now > 1) begin
            issue(CMD_POP, $urandom_range(0, 1), $urandom, $urandom);
          end else begin
            issue(CMD_LOOKUP_TOP, 1'b0, key, $urandom);
          end
        end
        pick = $urandom_range(0, 99);
        if (pick >= 12 && depth_now > 0) issue(CMD_POP, $urandom_range(0, 1), $urandom, $urandom);
        if (pick >= 85 && depth_now > 0) issue(CMD_POP, $urandom_range(0, 1), $urandom, $urandom);
      end
    end
  endtask

  initial begin
    int j;
    key_pool[0] = KEY_ONES;
    key_pool[1] = KEY_ONE;
    for (j = 2; j < KEY_POOL; j++) begin
      do key_pool[j] = $urandom; while (key_pool[j] == '0);
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed opening: bad arguments, shadowing, scope-limited lookups
    issue(CMD_POP, 1'b0, '0, '0);
    issue(CMD_LOOKUP_ALL, 1'b1, '0, KEY_ONES);
    issue(CMD_DEFINE, 1'b0, '0, 32'h0000_1234);
    issue(CMD_DEFINE, 1'b0, KEY_ONES, '0);
    issue(CMD_DEFINE, 1'b1, KEY_ONES, KEY_ONE);
    issue(CMD_DEFINE, 1'b0, KEY_ONE, KEY_ONES);
    issue(CMD_DEFINE, 1'b0, KEY_ONES, 32'h0000_0055);
    issue(CMD_LOOKUP_ALL, 1'b0, KEY_ONES, '0);
    issue(CMD_LOOKUP_TOP, 1'b0, KEY_ONES, '0);
    issue(CMD_PUSH, 1'b1, KEY_ONES, KEY_ONES);
    issue(CMD_LOOKUP_TOP, 1'b0, KEY_ONES, '0);
    issue(CMD_LOOKUP_ALL, 1'b0, KEY_ONES, '0);
    issue(CMD_DEFINE, 1'b0, KEY_ONES, 32'hA5A5_A5A5);
    issue(CMD_LOOKUP_ALL, 1'b0, KEY_ONES, '0);
    issue(CMD_PUSH, 1'b0, '0, '0);
    issue(CMD_LOOKUP_TOP, 1'b0, KEY_ONE, '0);
    issue(CMD_LOOKUP_ALL, 1'b1, KEY_ONE, '0);
    for (j = CMD_SPARE_LO; j <= CMD_SPARE_HI; j++) issue(3'(j), 1'b1, KEY_ONES, KEY_ONES);
    issue(CMD_POP, 1'b0, '0, '0);
    issue(CMD_POP, 1'b0, '0, '0);
    issue(CMD_POP, 1'b1, KEY_ONES, KEY_ONES);
    issue(CMD_LOOKUP_ALL, 1'b0, KEY_ONES, '0);

    run_phase(0, 0, 1'b0);
    run_phase(63, 0, 1'b1);
    run_phase(0, 63, 1'b0);
    run_phase(21, 21, 1'b1);

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
